// ----- rtl/cdtm_pkg.sv -----
// shared widths and constants for the collinear ditau mass pipeline
package cdtm_pkg;

    localparam int MOM_BITS    = 20;                  // input momentum / energy width
    localparam int MASS_BITS   = 20;                  // output mass width
    localparam int PROD_W      = 84;                  // den1*den2 magnitude, four 21-bit chunks
    localparam int DEN_W       = 80;                  // num^2
    localparam int NUM_W       = 124;                 // m2 * den1 * den2
    localparam int QUO_W       = 2 * MASS_BITS;       // quotient before the square root
    localparam int DIV_STAGES  = QUO_W + 1;           // overflow check plus one stage per bit
    localparam int SQRT_STAGES = MASS_BITS;
    localparam logic [MASS_BITS-1:0] MASS_MAX = {MASS_BITS{1'b1}};

endpackage

// ----- rtl/collinear_ditau_mass_core.sv -----
// collinear ditau mass core: deep pipeline from lepton and met words to mass
// throughput: one word per cycle while no skid word is held; the restoring divider (one quotient bit per stage)
//   and the digit-by-digit square root (one root bit per stage) set the depth
// a one-word skid buffer behind the output register keeps input ready registered
// reset (rst_n, async, active low) clears every valid bit; payload is not reset
module collinear_ditau_mass_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [cdtm_pkg::MOM_BITS-1:0]   lep0_px,
    input  logic signed [cdtm_pkg::MOM_BITS-1:0]   lep0_py,
    input  logic signed [cdtm_pkg::MOM_BITS-1:0]   lep0_pz,
    input  logic        [cdtm_pkg::MOM_BITS-1:0]   lep0_energy,
    input  logic signed [cdtm_pkg::MOM_BITS-1:0]   lep1_px,
    input  logic signed [cdtm_pkg::MOM_BITS-1:0]   lep1_py,
    input  logic signed [cdtm_pkg::MOM_BITS-1:0]   lep1_pz,
    input  logic        [cdtm_pkg::MOM_BITS-1:0]   lep1_energy,
    input  logic signed [cdtm_pkg::MOM_BITS-1:0]   miss_px,
    input  logic signed [cdtm_pkg::MOM_BITS-1:0]   miss_py,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic        [cdtm_pkg::MASS_BITS-1:0]  coll_mass,
    output logic                                   possible,
    output logic                                   saturated
);
    import cdtm_pkg::*;

    // whole pipeline moves together; it only halts while the skid word is held
    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // ---------------------------------------------------------------
    // stage 1: transverse cross-product terms and four-momentum sums
    // ---------------------------------------------------------------
    logic                 s1_vld_reg;
    logic signed [39:0]   s1_pa_reg, s1_pb_reg, s1_pc_reg, s1_pd_reg, s1_pe_reg, s1_pf_reg;
    logic        [20:0]   s1_es_reg;
    logic signed [20:0]   s1_xs_reg, s1_ys_reg, s1_zs_reg;

    // stage 2: num, den1, den2 and the squares of the sums
    logic                 s2_vld_reg;
    logic signed [40:0]   s2_num_reg;
    logic signed [41:0]   s2_den1_reg, s2_den2_reg;
    logic        [41:0]   s2_esq_reg;
    logic signed [41:0]   s2_xsq_reg, s2_ysq_reg, s2_zsq_reg;

    // stage 3: clamped m^2, magnitudes, feasibility
    logic                 s3_vld_reg;
    logic                 s3_poss_reg;
    logic        [41:0]   s3_m2_reg;
    logic        [39:0]   s3_anum_reg;
    logic        [40:0]   s3_aden1_reg, s3_aden2_reg;

    // stage 4: partial products of den1*den2 and num^2
    logic                 s4_vld_reg;
    logic                 s4_poss_reg;
    logic        [41:0]   s4_m2_reg;
    logic        [41:0]   s4_pll_reg;
    logic        [40:0]   s4_plh_reg, s4_phl_reg;
    logic        [39:0]   s4_phh_reg;
    logic        [39:0]   s4_nll_reg, s4_nlh_reg, s4_nhh_reg;

    // stage 5: den product and divisor
    logic                 s5_vld_reg;
    logic                 s5_poss_reg;
    logic        [41:0]   s5_m2_reg;
    logic        [PROD_W-1:0] s5_prod_reg;
    logic        [DEN_W-1:0]  s5_d_reg;

    // stage 6: partial products of m^2 * den product
    logic                 s6_vld_reg;
    logic                 s6_poss_reg;
    logic        [41:0]   s6_pp_reg [0:7];
    logic        [DEN_W-1:0]  s6_d_reg;

    // stage 7: two row sums
    logic                 s7_vld_reg;
    logic                 s7_poss_reg;
    logic        [106:0]  s7_r0_reg, s7_r1_reg;
    logic        [DEN_W-1:0]  s7_d_reg;

    // stage 8: dividend
    logic                 s8_vld_reg;
    logic                 s8_poss_reg;
    logic        [NUM_W-1:0]  s8_n_reg;
    logic        [DEN_W-1:0]  s8_d_reg;

    // combinational helpers
    logic signed [43:0]   m2_full;
    logic        [40:0]   anum_full;
    logic        [41:0]   aden1_full, aden2_full;
    logic                 poss_next;

    always_comb
    begin
        m2_full    = 44'(s2_esq_reg) - 44'(s2_xsq_reg) - 44'(s2_ysq_reg) - 44'(s2_zsq_reg);
        anum_full  = s2_num_reg[40]  ? 41'(-s2_num_reg)  : 41'(s2_num_reg);
        aden1_full = s2_den1_reg[41] ? 42'(-s2_den1_reg) : 42'(s2_den1_reg);
        aden2_full = s2_den2_reg[41] ? 42'(-s2_den2_reg) : 42'(s2_den2_reg);
        poss_next  = (s2_num_reg != '0) && (s2_den1_reg != '0) && (s2_den2_reg != '0)
                     && (s2_den1_reg[41] == s2_den2_reg[41]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= s7_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            s1_pa_reg <= 40'(lep0_px) * 40'(lep1_py);
            s1_pb_reg <= 40'(lep0_py) * 40'(lep1_px);
            s1_pc_reg <= 40'(lep1_py) * 40'(miss_px);
            s1_pd_reg <= 40'(lep1_px) * 40'(miss_py);
            s1_pe_reg <= 40'(lep0_px) * 40'(miss_py);
            s1_pf_reg <= 40'(lep0_py) * 40'(miss_px);
            s1_es_reg <= 21'(lep0_energy) + 21'(lep1_energy);
            s1_xs_reg <= 21'(lep0_px) + 21'(lep1_px);
            s1_ys_reg <= 21'(lep0_py) + 21'(lep1_py);
            s1_zs_reg <= 21'(lep0_pz) + 21'(lep1_pz);
            // stage 2
            s2_num_reg  <= 41'(s1_pa_reg) - 41'(s1_pb_reg);
            s2_den1_reg <= 42'(s1_pc_reg) - 42'(s1_pd_reg) + 42'(s1_pa_reg) - 42'(s1_pb_reg);
            s2_den2_reg <= 42'(s1_pe_reg) - 42'(s1_pf_reg) + 42'(s1_pa_reg) - 42'(s1_pb_reg);
            s2_esq_reg  <= 42'(s1_es_reg) * 42'(s1_es_reg);
            s2_xsq_reg  <= 42'(s1_xs_reg) * 42'(s1_xs_reg);
            s2_ysq_reg  <= 42'(s1_ys_reg) * 42'(s1_ys_reg);
            s2_zsq_reg  <= 42'(s1_zs_reg) * 42'(s1_zs_reg);
            // stage 3: negative m^2 clamps to zero
            s3_poss_reg  <= poss_next;
            s3_m2_reg    <= m2_full[43] ? '0 : m2_full[41:0];
            s3_anum_reg  <= anum_full[39:0];
            s3_aden1_reg <= aden1_full[40:0];
            s3_aden2_reg <= aden2_full[40:0];
            // stage 4
            s4_poss_reg <= s3_poss_reg;
            s4_m2_reg   <= s3_m2_reg;
            s4_pll_reg  <= 42'(s3_aden1_reg[20:0]) * 42'(s3_aden2_reg[20:0]);
            s4_plh_reg  <= 41'(s3_aden1_reg[20:0]) * 41'(s3_aden2_reg[40:21]);
            s4_phl_reg  <= 41'(s3_aden1_reg[40:21]) * 41'(s3_aden2_reg[20:0]);
            s4_phh_reg  <= 40'(s3_aden1_reg[40:21]) * 40'(s3_aden2_reg[40:21]);
            s4_nll_reg  <= 40'(s3_anum_reg[19:0]) * 40'(s3_anum_reg[19:0]);
            s4_nlh_reg  <= 40'(s3_anum_reg[19:0]) * 40'(s3_anum_reg[39:20]);
            s4_nhh_reg  <= 40'(s3_anum_reg[39:20]) * 40'(s3_anum_reg[39:20]);
            // stage 5
            s5_poss_reg <= s4_poss_reg;
            s5_m2_reg   <= s4_m2_reg;
            s5_prod_reg <= (PROD_W'(s4_phh_reg) << 42) + (PROD_W'(s4_plh_reg) << 21)
                           + (PROD_W'(s4_phl_reg) << 21) + PROD_W'(s4_pll_reg);
            s5_d_reg    <= (DEN_W'(s4_nhh_reg) << 40) + (DEN_W'(s4_nlh_reg) << 21)
                           + DEN_W'(s4_nll_reg);
            // stage 6: 21-bit chunks of m^2 times 21-bit chunks of the den product
            s6_poss_reg <= s5_poss_reg;
            s6_d_reg    <= s5_d_reg;
            for (int j = 0; j < 4; j++)
            begin
                s6_pp_reg[j]     <= 42'(s5_m2_reg[20:0])  * 42'(s5_prod_reg[21*j +: 21]);
                s6_pp_reg[j + 4] <= 42'(s5_m2_reg[41:21]) * 42'(s5_prod_reg[21*j +: 21]);
            end
            // stage 7
            s7_poss_reg <= s6_poss_reg;
            s7_d_reg    <= s6_d_reg;
            s7_r0_reg   <= 107'(s6_pp_reg[0]) + (107'(s6_pp_reg[1]) << 21)
                           + (107'(s6_pp_reg[2]) << 42) + (107'(s6_pp_reg[3]) << 63);
            s7_r1_reg   <= 107'(s6_pp_reg[4]) + (107'(s6_pp_reg[5]) << 21)
                           + (107'(s6_pp_reg[6]) << 42) + (107'(s6_pp_reg[7]) << 63);
            // stage 8
            s8_poss_reg <= s7_poss_reg;
            s8_d_reg    <= s7_d_reg;
            s8_n_reg    <= (NUM_W'(s7_r1_reg) << 21) + NUM_W'(s7_r0_reg);
        end
    end

    // ---------------------------------------------------------------
    // restoring divider: first stage checks overflow (n >= d << 40),
    // then one quotient bit per stage
    // ---------------------------------------------------------------
    logic              dv_vld_reg  [0:DIV_STAGES-1];
    logic              dv_poss_reg [0:DIV_STAGES-1];
    logic              dv_sat_reg  [0:DIV_STAGES-1];
    logic [NUM_W-1:0]  dv_rem_reg  [0:DIV_STAGES-1];
    logic [DEN_W-1:0]  dv_d_reg    [0:DIV_STAGES-1];
    logic [QUO_W-1:0]  dv_q_reg    [0:DIV_STAGES-1];

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        localparam int SH = DIV_STAGES - 1 - j;
        logic              vld_in, poss_in, sat_in, ge;
        logic [NUM_W-1:0]  rem_in, dsh;
        logic [DEN_W-1:0]  d_in;
        logic [QUO_W-1:0]  q_in;

        if (j == 0)
        begin : g_first
            assign vld_in  = s8_vld_reg;
            assign poss_in = s8_poss_reg;
            assign sat_in  = 1'b0;
            assign rem_in  = s8_n_reg;
            assign d_in    = s8_d_reg;
            assign q_in    = '0;
        end
        else
        begin : g_next
            assign vld_in  = dv_vld_reg[j-1];
            assign poss_in = dv_poss_reg[j-1];
            assign sat_in  = dv_sat_reg[j-1];
            assign rem_in  = dv_rem_reg[j-1];
            assign d_in    = dv_d_reg[j-1];
            assign q_in    = dv_q_reg[j-1];
        end

        assign dsh = NUM_W'(d_in) << SH;
        assign ge  = (rem_in >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j] <= 1'b0;
            else if (en)
                dv_vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_poss_reg[j] <= poss_in;
                dv_d_reg[j]    <= d_in;
                if (j == 0)
                begin
                    dv_sat_reg[j] <= ge;
                    dv_rem_reg[j] <= rem_in;
                    dv_q_reg[j]   <= q_in;
                end
                else
                begin
                    dv_sat_reg[j] <= sat_in;
                    dv_rem_reg[j] <= ge ? rem_in - dsh : rem_in;
                    dv_q_reg[j]   <= {q_in[QUO_W-2:0], ge};
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // digit-by-digit integer square root, one root bit per stage
    // ---------------------------------------------------------------
    logic              sq_vld_reg  [0:SQRT_STAGES-1];
    logic              sq_poss_reg [0:SQRT_STAGES-1];
    logic              sq_sat_reg  [0:SQRT_STAGES-1];
    logic [QUO_W-1:0]  sq_op_reg   [0:SQRT_STAGES-1];
    logic [QUO_W-1:0]  sq_res_reg  [0:SQRT_STAGES-1];

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_sqrt
        localparam logic [QUO_W-1:0] ONE = QUO_W'(1) << (2 * (SQRT_STAGES - 1 - i));
        logic              vld_in, poss_in, sat_in, ge;
        logic [QUO_W-1:0]  op_in, res_in;
        logic [QUO_W:0]    trial;

        if (i == 0)
        begin : g_first
            assign vld_in  = dv_vld_reg[DIV_STAGES-1];
            assign poss_in = dv_poss_reg[DIV_STAGES-1];
            assign sat_in  = dv_sat_reg[DIV_STAGES-1];
            assign op_in   = dv_q_reg[DIV_STAGES-1];
            assign res_in  = '0;
        end
        else
        begin : g_next
            assign vld_in  = sq_vld_reg[i-1];
            assign poss_in = sq_poss_reg[i-1];
            assign sat_in  = sq_sat_reg[i-1];
            assign op_in   = sq_op_reg[i-1];
            assign res_in  = sq_res_reg[i-1];
        end

        assign trial = (QUO_W+1)'(res_in) + (QUO_W+1)'(ONE);
        assign ge    = ((QUO_W+1)'(op_in) >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[i] <= 1'b0;
            else if (en)
                sq_vld_reg[i] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_poss_reg[i] <= poss_in;
                sq_sat_reg[i]  <= sat_in;
                sq_op_reg[i]   <= ge ? op_in - trial[QUO_W-1:0] : op_in;
                sq_res_reg[i]  <= ge ? (res_in >> 1) + ONE : (res_in >> 1);
            end
        end
    end

    // ---------------------------------------------------------------
    // result selection, output register and skid word
    // ---------------------------------------------------------------
    logic                  last_vld;
    logic [MASS_BITS-1:0]  last_mass;
    logic                  last_poss, last_sat;

    always_comb
    begin
        last_vld  = sq_vld_reg[SQRT_STAGES-1];
        last_poss = sq_poss_reg[SQRT_STAGES-1];
        last_sat  = last_poss && sq_sat_reg[SQRT_STAGES-1];
        if (!last_poss)
            last_mass = '0;
        else if (last_sat)
            last_mass = MASS_MAX;
        else
            last_mass = sq_res_reg[SQRT_STAGES-1][MASS_BITS-1:0];
    end

    logic                  out_valid_reg;
    logic [MASS_BITS-1:0]  out_mass_reg, skid_mass_reg;
    logic                  out_poss_reg, out_sat_reg, skid_poss_reg, skid_sat_reg;
    logic                  out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= skid_valid_reg || last_vld;
            if (skid_valid_reg && out_free)
                skid_valid_reg <= 1'b0;
            else if (en && last_vld && !out_free)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_mass_reg <= skid_mass_reg;
                out_poss_reg <= skid_poss_reg;
                out_sat_reg  <= skid_sat_reg;
            end
            else
            begin
                out_mass_reg <= last_mass;
                out_poss_reg <= last_poss;
                out_sat_reg  <= last_sat;
            end
        end
        if (en && !out_free)
        begin
            skid_mass_reg <= last_mass;
            skid_poss_reg <= last_poss;
            skid_sat_reg  <= last_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign coll_mass = out_mass_reg;
    assign possible  = out_poss_reg;
    assign saturated = out_sat_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // skid word only exists behind a held output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    // an impossible solution never reports a mass or saturation
    a_impossible_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_poss_reg) |-> (out_mass_reg == '0 && !out_sat_reg))
        else $error("impossible solution with nonzero result");

    // saturation always carries the full-scale mass
    a_sat_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sat_reg) |-> (out_mass_reg == MASS_MAX))
        else $error("saturated word without full-scale mass");

    // while the skid word is held the pipeline does not advance
    a_halt_on_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_ready) |=> $stable(s8_n_reg))
        else $error("pipeline moved while stalled");

endmodule
